/* rtl/core/lag_pkg.sv */
// ----------------------------------------------------------------------------
// lag_pkg: shared types and constants for the Life generation block
// Grid geometry, row types and the transaction structs of both channels.
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int GRID_SIDE = 32;
  localparam int ROW_W     = GRID_SIDE;
  localparam int ADDR_W    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int CNT_W     = $clog2(GRID_SIDE + 2);

  localparam logic [1:0] FUNC_TOGGLE = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_STEP   = 2'd2;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] col;
    logic [5:0] row;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  row_index;
    logic [31:0] row_cells;
    logic        last;
    logic        changed;
    logic        ended;
    logic        running;
  } out_item_t;

endpackage

/* rtl/core/life_automaton_generation.sv */
// ----------------------------------------------------------------------------
// life_automaton_generation: Life (B3/S23) grid with toggle, start and step
// Keeps a GRID_SIDE x GRID_SIDE grid in a row memory and advances it one
// generation per step transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready transaction carrying func, col, row.
//   out_* : valid/ready transaction carrying one result row or status word.
//   Toggle, start and unused codes give one status transaction (last = 1).
//   It is offered from the status state, entered straight from idle for
//   start, the unused code and an ignored edit, and after the write state
//   for an applied edit. A step sweeps the grid one row per cycle through a
//   three-row window and the shared row-rule unit, writing each new row
//   back in place. Then GRID_SIDE row transactions follow, one per cycle
//   while out_ready is high, the last one marked.
//   in_ready is high only when idle; one transaction is in work at a time.
//   When the receiver stalls, the pending result holds until taken.
//   Reset (rst_n low, synchronous) empties the grid through per-row valid
//   bits and clears the started and static flags.
// ----------------------------------------------------------------------------
module life_automaton_generation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lag_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lag_pkg::out_item_t out_data
);
  import lag_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TOG  = 3'd1;
  localparam logic [2:0] ST_STAT = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(GRID_SIDE + 1);
  localparam logic [CNT_W-1:0]  CNT_SIDE = CNT_W'(GRID_SIDE);
  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(GRID_SIDE - 1);

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]    row_r, row_nxt;
  logic [ADDR_W-1:0]    col_r, col_nxt;
  logic                 started_r, started_nxt;
  logic                 static_r, static_nxt;
  logic                 chg_r, chg_nxt;
  logic [GRID_SIDE-1:0] nz_r;
  row_t                 up_r, up_nxt;
  row_t                 mid_r, mid_nxt;

  row_t                 mem [GRID_SIDE];
  row_t                 rd_data_r;
  logic                 rd_nz_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  row_t                 wr_data;

  row_t                 rd_row;
  row_t                 below;
  row_t                 rule_row;
  logic                 in_acc;
  logic                 out_acc;
  logic                 tog_ok;

  assign rd_row  = rd_nz_r ? rd_data_r : '0;
  assign below   = (cnt_r == CNT_END) ? '0 : rd_row;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign tog_ok  = !started_r && ({1'b0, in_data.col} < 7'(GRID_SIDE))
                   && ({1'b0, in_data.row} < 7'(GRID_SIDE));

  lag_row_rule u_rule (
    .row_up  (up_r),
    .row_mid (mid_r),
    .row_dn  (below),
    .row_nxt (rule_row)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r    <= '0;
      rd_nz_r <= 1'b0;
    end else begin
      rd_nz_r <= nz_r[rd_addr];
      if (wr_en) begin
        nz_r[wr_addr] <= |wr_data;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: rd_addr = ADDR_W'(in_data.row);
      ST_TOG:  rd_addr = row_r;
      ST_STEP: rd_addr = (cnt_r < CNT_SIDE) ? ADDR_W'(cnt_r) : '0;
      ST_EMIT: rd_addr = (out_ready && idx_r != LAST_ROW) ? idx_r + 1'b1 : idx_r;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    started_nxt = started_r;
    static_nxt  = static_r;
    chg_nxt     = chg_r;
    up_nxt      = up_r;
    mid_nxt     = mid_r;
    wr_en       = 1'b0;
    wr_addr     = row_r;
    wr_data     = rd_row ^ (row_t'(1) << col_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          chg_nxt = 1'b0;
          row_nxt = ADDR_W'(in_data.row);
          col_nxt = ADDR_W'(in_data.col);
          priority if (in_data.func == FUNC_TOGGLE && tog_ok) begin
            state_nxt = ST_TOG;
          end else if (in_data.func == FUNC_STEP) begin
            state_nxt = ST_STEP;
            cnt_nxt   = '0;
            up_nxt    = '0;
            mid_nxt   = '0;
          end else begin
            if (in_data.func == FUNC_START) begin
              started_nxt = 1'b1;
            end
            state_nxt = ST_STAT;
          end
        end
      end
      ST_TOG: begin
        wr_en     = 1'b1;
        chg_nxt   = 1'b1;
        state_nxt = ST_STAT;
      end
      ST_STAT: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          up_nxt  = mid_r;
          mid_nxt = below;
        end
        if (cnt_r >= CNT_W'(2)) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(cnt_r - CNT_W'(2));
          wr_data = rule_row;
          chg_nxt = chg_r | (rule_row != mid_r);
        end
        if (cnt_r == CNT_END) begin
          static_nxt = static_r | !chg_nxt;
          idx_nxt    = '0;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (idx_r == LAST_ROW) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      idx_r     <= '0;
      started_r <= 1'b0;
      static_r  <= 1'b0;
      chg_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
      static_r  <= static_nxt;
      chg_r     <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    up_r  <= up_nxt;
    mid_r <= mid_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_STAT) || (state_r == ST_EMIT);

  always_comb begin
    out_data.row_index = (state_r == ST_EMIT) ? 6'(idx_r) : 6'd0;
    out_data.row_cells = (state_r == ST_EMIT) ? 32'(rd_row) : 32'd0;
    out_data.last      = (state_r == ST_STAT) || (idx_r == LAST_ROW);
    out_data.changed   = chg_r;
    out_data.ended     = !(|nz_r) || static_r;
    out_data.running   = started_r;
  end

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels active together");

  a_sweep_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && cnt_r == CNT_END) |=> (state_r == ST_EMIT && idx_r == '0))
    else $error("row sweep did not hand over to row zero");

  a_toggle_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TOG) |-> ($countones(wr_data ^ rd_row) == 1))
    else $error("toggle write altered other than one cell");

  a_static_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    static_r |=> static_r)
    else $error("static flag dropped");
`endif

endmodule

/* rtl/core/lag_row_rule.sv */
// ----------------------------------------------------------------------------
// lag_row_rule: B3/S23 next state for one grid row
// Takes the rows above, at and below the target and returns its next row;
// cells outside the grid count as dead.
// ----------------------------------------------------------------------------
module lag_row_rule (
  input  lag_pkg::row_t row_up,
  input  lag_pkg::row_t row_mid,
  input  lag_pkg::row_t row_dn,
  output lag_pkg::row_t row_nxt
);
  import lag_pkg::*;

  row_t up_l, up_r, mid_l, mid_r, dn_l, dn_r;

  assign up_l  = row_up  << 1;
  assign up_r  = row_up  >> 1;
  assign mid_l = row_mid << 1;
  assign mid_r = row_mid >> 1;
  assign dn_l  = row_dn  << 1;
  assign dn_r  = row_dn  >> 1;

  always_comb begin
    logic [3:0] n;
    row_nxt = '0;
    for (int c = 0; c < ROW_W; c++) begin
      n = 4'(up_l[c]) + 4'(row_up[c]) + 4'(up_r[c])
        + 4'(mid_l[c]) + 4'(mid_r[c])
        + 4'(dn_l[c]) + 4'(row_dn[c]) + 4'(dn_r[c]);
      row_nxt[c] = (n == 4'd3) || (row_mid[c] && (n == 4'd2));
    end
  end

endmodule
